>>> rtl/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

	// Coordinate and datapath widths. A difference of two coordinates needs one
	// more bit, a square twice the coordinate width plus one, a sum one more.
	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * COORD_W + 1;
	localparam int RAD_W   = SQ_W + 1;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 1;
	localparam int TOTAL_W = 40;
	localparam int COUNT_W = 16;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Configuration port: 64-bit registers at 8-byte strides.
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 64;
	localparam int ADDR_LSB = 3;
	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic                      is_first;
		logic                      is_last;
	} plc_point_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_distance;
		logic [COUNT_W-1:0] point_count;
		logic               status;
	} plc_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_START,
		ST_ROOT,
		ST_ACCUM,
		ST_EMIT
	} plc_state_t;

endpackage

>>> rtl/plc_isqrt.sv
`timescale 1ns / 1ps

// Restoring integer square root, one result bit per cycle.
module plc_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plc_pkg::RAD_W-1:0]     radicand,
	output logic                          done,
	output logic [plc_pkg::ROOT_W-1:0]    root
);

	localparam int CNT_W = $clog2(plc_pkg::ROOT_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [plc_pkg::RAD_W-1:0]   rad_q;
	logic [plc_pkg::REM_W-1:0]   rem_q;
	logic [plc_pkg::ROOT_W-1:0]  root_q;

	logic [plc_pkg::REM_W+1:0]   rem_ext;
	logic [plc_pkg::REM_W+1:0]   trial;
	logic                        fits;

	always_comb begin
		rem_ext = {rem_q, rad_q[plc_pkg::RAD_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		fits    = (rem_ext >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(plc_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[plc_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? plc_pkg::REM_W'(rem_ext - trial) : plc_pkg::REM_W'(rem_ext);
			root_q <= {root_q[plc_pkg::ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("square root did not start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("square root reported done while still iterating");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == '0)
		else $error("square root reported done before its last bit");

endmodule

>>> rtl/path_length_limit_check.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// pt        in         pt_valid / pt_stall  plc_point_t (coord_x, coord_y, is_first, is_last)
// res       out        res_valid/res_stall  plc_result_t (total_distance, point_count, status)
// config    in         APB-style, pready=1  distance_limit at byte address 0, 64-bit data
//
// A point that starts a route is taken while the block stays in ST_IDLE; a point with
// is_last set also passes ST_EMIT to move its result into the output register. Any
// other point passes ST_IDLE where it is accepted, ST_SQUARE to square, ST_START to
// sum and start the root, ST_ROOT for the bit-serial square root (one root bit per
// cycle) until it is seen done, then ST_ACCUM to accumulate. The root loop sets the rate.
// arst_n clears the route state, the limit and the output valid at once.
// A stalled result sits in the output register while the next point is taken in;
// only a new result waits for it to drain.
module path_length_limit_check (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                pt_valid,
	output logic                                pt_stall,
	input  plc_pkg::plc_point_t                 pt,

	output logic                                res_valid,
	input  logic                                res_stall,
	output plc_pkg::plc_result_t                res,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [plc_pkg::ADDR_W-1:0]          paddr,
	input  logic [plc_pkg::DATA_W-1:0]          pwdata,
	output logic [plc_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	plc_pkg::plc_state_t state_q, state_next;

	// Configuration register.
	logic [plc_pkg::TOTAL_W-1:0] limit_q;

	// Route state.
	logic signed [plc_pkg::COORD_W-1:0] prev_x_q, prev_y_q;
	logic [plc_pkg::TOTAL_W-1:0]        total_q;
	logic [plc_pkg::COUNT_W-1:0]        count_q;
	logic                               last_q;

	// Segment datapath: differences, then squares.
	logic signed [plc_pkg::DIFF_W-1:0]  dx_s1, dy_s1;
	logic [plc_pkg::SQ_W-1:0]           sqx_s2, sqy_s2;
	logic signed [2*plc_pkg::DIFF_W-1:0] prod_x, prod_y;

	// Output register.
	logic                  res_valid_q;
	plc_pkg::plc_result_t  res_q;

	logic                         pt_accept;
	logic                         emit_free;
	logic                         root_start;
	logic                         root_done;
	logic [plc_pkg::ROOT_W-1:0]   root;
	logic [plc_pkg::RAD_W-1:0]    radicand;
	logic [plc_pkg::TOTAL_W:0]    total_sum;
	logic                         cfg_write;

	assign pt_accept = pt_valid && !pt_stall;
	assign emit_free = !res_valid_q || !res_stall;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prod_x    = dx_s1 * dx_s1;
		prod_y    = dy_s1 * dy_s1;
		radicand  = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		total_sum = {1'b0, total_q} + (plc_pkg::TOTAL_W + 1)'(root);
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			plc_pkg::ST_IDLE: begin
				if (pt_accept) begin
					if (!pt.is_first) begin
						state_next = plc_pkg::ST_SQUARE;
					end else if (pt.is_last) begin
						state_next = plc_pkg::ST_EMIT;
					end
				end
			end
			plc_pkg::ST_SQUARE: begin
				state_next = plc_pkg::ST_START;
			end
			plc_pkg::ST_START: begin
				state_next = plc_pkg::ST_ROOT;
			end
			plc_pkg::ST_ROOT: begin
				if (root_done) begin
					state_next = plc_pkg::ST_ACCUM;
				end
			end
			plc_pkg::ST_ACCUM: begin
				state_next = last_q ? plc_pkg::ST_EMIT : plc_pkg::ST_IDLE;
			end
			plc_pkg::ST_EMIT: begin
				if (emit_free) begin
					state_next = plc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = plc_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		pt_stall   = 1'b1;
		root_start = 1'b0;
		unique case (state_q)
			plc_pkg::ST_IDLE:  pt_stall = 1'b0;
			plc_pkg::ST_START: root_start = 1'b1;
			default: begin
				pt_stall   = 1'b1;
				root_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plc_pkg::ST_IDLE;
			limit_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			total_q     <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;

			if (cfg_write && paddr[plc_pkg::ADDR_LSB] == plc_pkg::REG_LIMIT) begin
				limit_q <= pwdata[plc_pkg::TOTAL_W-1:0];
			end

			if (pt_accept) begin
				prev_x_q <= pt.coord_x;
				prev_y_q <= pt.coord_y;
				last_q   <= pt.is_last;
				if (pt.is_first) begin
					total_q <= '0;
					count_q <= plc_pkg::COUNT_W'(1);
				end else if (count_q != plc_pkg::COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end

			// The sum saturates at the largest total instead of wrapping.
			if (state_q == plc_pkg::ST_ACCUM) begin
				if (total_sum >= {1'b0, plc_pkg::TOTAL_MAX}) begin
					total_q <= plc_pkg::TOTAL_MAX;
				end else begin
					total_q <= total_sum[plc_pkg::TOTAL_W-1:0];
				end
			end

			if (state_q == plc_pkg::ST_EMIT && emit_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (pt_accept) begin
			dx_s1 <= {pt.coord_x[plc_pkg::COORD_W-1], pt.coord_x}
				- {prev_x_q[plc_pkg::COORD_W-1], prev_x_q};
			dy_s1 <= {pt.coord_y[plc_pkg::COORD_W-1], pt.coord_y}
				- {prev_y_q[plc_pkg::COORD_W-1], prev_y_q};
		end
		if (state_q == plc_pkg::ST_SQUARE) begin
			sqx_s2 <= prod_x[plc_pkg::SQ_W-1:0];
			sqy_s2 <= prod_y[plc_pkg::SQ_W-1:0];
		end
		if (state_q == plc_pkg::ST_EMIT && emit_free) begin
			res_q.total_distance <= total_q;
			res_q.point_count    <= count_q;
			res_q.status         <= (total_q > limit_q);
		end
	end

	plc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.done     (root_done),
		.root     (root)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[plc_pkg::ADDR_LSB] == plc_pkg::REG_LIMIT)
		? plc_pkg::DATA_W'(limit_q) : '0;

	a_first_last_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pt_accept && pt.is_first && pt.is_last |=> state_q == plc_pkg::ST_EMIT)
		else $error("a one-point route did not go straight to its result");

	a_root_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == plc_pkg::ST_ROOT)
		else $error("square root finished outside its wait state");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plc_pkg::ST_ACCUM |=> total_q >= $past(total_q))
		else $error("running total decreased while accumulating");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pt_accept && !pt.is_first && count_q == plc_pkg::COUNT_MAX
		|=> count_q == plc_pkg::COUNT_MAX)
		else $error("point count wrapped");

endmodule

>>> sim/path_length_limit_check_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the route length checker. Points go in over the pt channel,
// route reports come back over the res channel, and the limit register is written and
// read back over the APB-style port while the block is idle.
module path_length_limit_check_tb;

	// Margin for a measured point to pass the square root and the output register.
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 250000;
	localparam int RANDOM_ITEMS  = 750;
	localparam int PHASE_ITEMS   = 125;
	localparam int MAX_REPORTS   = 10;

	localparam logic signed [plc_pkg::COORD_W-1:0] COORD_MIN =
		{1'b1, {(plc_pkg::COORD_W-1){1'b0}}};
	localparam logic signed [plc_pkg::COORD_W-1:0] COORD_MAX =
		{1'b0, {(plc_pkg::COORD_W-1){1'b1}}};
	localparam logic [plc_pkg::ADDR_W-1:0] LIMIT_ADDR =
		plc_pkg::ADDR_W'(plc_pkg::REG_LIMIT) << plc_pkg::ADDR_LSB;

	logic clk = 1'b0;
	logic arst_n;

	logic                 pt_valid;
	logic                 pt_stall;
	plc_pkg::plc_point_t  pt;

	logic                 res_valid;
	logic                 res_stall = 1'b0;
	plc_pkg::plc_result_t res;

	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [plc_pkg::ADDR_W-1:0]   paddr;
	logic [plc_pkg::DATA_W-1:0]   pwdata;
	logic [plc_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	// Our own copy of the route state, updated on every accepted point, and of the limit.
	logic signed [plc_pkg::COORD_W-1:0] prev_x;
	logic signed [plc_pkg::COORD_W-1:0] prev_y;
	logic [plc_pkg::TOTAL_W-1:0]        run_total;
	logic [plc_pkg::COUNT_W-1:0]        run_count;
	logic [plc_pkg::TOTAL_W-1:0]        limit_reg;

	// Route reports that the block still owes us, oldest first.
	plc_pkg::plc_result_t expected_reports[$];
	plc_pkg::plc_result_t report_due;

	int  mismatches = 0;
	int  readback_errors = 0;
	int  cycle_count = 0;
	int  res_wait = 0;
	int  taken_reports = 0;
	int  seen_reports = 0;
	bit  idle_on = 1'b1;

	path_length_limit_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.pt        (pt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a lost report or a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic plc_pkg::plc_point_t route_point(
			input logic signed [plc_pkg::COORD_W-1:0] x,
			input logic signed [plc_pkg::COORD_W-1:0] y, input logic first, input logic last);
		plc_pkg::plc_point_t p;
		p.coord_x  = x;
		p.coord_y  = y;
		p.is_first = first;
		p.is_last  = last;
		return p;
	endfunction

	// Advance the route state by one accepted point. The segment length is the floor
	// square root of dx*dx + dy*dy, found one root bit at a time from the top. The
	// radicand stays below 2^50, so the root fits in 26 bits.
	task automatic track_point(input plc_pkg::plc_point_t p);
		longint      dx;
		longint      dy;
		logic [63:0] radicand;
		logic [63:0] root;
		logic [63:0] trial;
		logic [63:0] room;
		plc_pkg::plc_result_t rep;
		if (p.is_first) begin
			run_total = '0;
			run_count = '0;
		end else begin
			dx = longint'($signed(p.coord_x)) - longint'($signed(prev_x));
			dy = longint'($signed(p.coord_y)) - longint'($signed(prev_y));
			radicand = dx * dx + dy * dy;
			root = '0;
			for (int b = 25; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= radicand)
					root = trial;
			end
			// The total holds at its maximum instead of wrapping.
			room = 64'(plc_pkg::TOTAL_MAX - run_total);
			if (root >= room)
				run_total = plc_pkg::TOTAL_MAX;
			else
				run_total = run_total + root[plc_pkg::TOTAL_W-1:0];
		end
		if (run_count != plc_pkg::COUNT_MAX)
			run_count++;
		prev_x = p.coord_x;
		prev_y = p.coord_y;
		if (p.is_last) begin
			rep.total_distance = run_total;
			rep.point_count    = run_count;
			rep.status         = (run_total > limit_reg);
			expected_reports.push_back(rep);
		end
	endtask

	// Send one point: wait a random gap, present it at a falling edge and hold it until
	// a rising edge sees it taken. Valid is left high so that a following point can go
	// out back to back; wait_drain lowers it.
	task automatic send_point(input plc_pkg::plc_point_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			pt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pt_valid <= 1'b1;
		pt       <= p;
		@(posedge clk);
		while (pt_stall)
			@(posedge clk);
		track_point(p);
	endtask

	// Stop sending, wait for every owed report, then give a point without a report
	// time to finish inside the block.
	task automatic wait_drain();
		@(negedge clk);
		pt_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the limit register, then read it back. The bits above the register carry
	// random junk that the block must drop.
	task automatic write_limit(input logic [plc_pkg::TOTAL_W-1:0] value);
		logic [plc_pkg::DATA_W-1:0] word;
		word = {$urandom, $urandom};
		word[plc_pkg::TOTAL_W-1:0] = value;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		limit_reg = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[plc_pkg::TOTAL_W-1:0] !== value) begin
			readback_errors++;
			if (mismatches + readback_errors <= MAX_REPORTS)
				$display("limit readback: expected %0d, got %0d", value,
					prdata[plc_pkg::TOTAL_W-1:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver stall: after each taken report a new random wait is drawn, none when
	// idle_on is clear, and it only counts down while a report is being offered.
	always @(negedge clk) begin
		if (seen_reports != taken_reports) begin
			seen_reports = taken_reports;
			res_wait = idle_on ? $urandom_range(0, 7) : 0;
		end
		if (res_valid && res_wait > 0) begin
			res_stall <= 1'b1;
			res_wait = res_wait - 1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Compare each taken report with the oldest one owed.
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches + readback_errors <= MAX_REPORTS)
					$display("unexpected report: total %0d count %0d status %0d",
						res.total_distance, res.point_count, res.status);
			end else begin
				report_due = expected_reports.pop_front();
				if (res.total_distance !== report_due.total_distance ||
						res.point_count !== report_due.point_count ||
						res.status !== report_due.status) begin
					mismatches++;
					if (mismatches + readback_errors <= MAX_REPORTS)
						$display("report: expected total %0d count %0d status %0d,",
							report_due.total_distance, report_due.point_count,
							report_due.status,
							" got total %0d count %0d status %0d",
							res.total_distance, res.point_count, res.status);
				end
			end
			taken_reports++;
		end
	end

	// A point that follows reset without a route start is measured from the origin.
	// The limit is still at its reset value of zero, so any nonzero length exceeds it,
	// and the report must still carry the total and the count.
	task automatic test_unstarted_route();
		send_point(route_point(24'sd768, 24'sd1024, 1'b0, 1'b1));
		wait_drain();
	endtask

	// A route of one point reports zero length, a count of one and no excess.
	task automatic test_single_point_route();
		send_point(route_point(24'sd5, -24'sd7, 1'b1, 1'b1));
		wait_drain();
	endtask

	// Points after a report without a route start extend the old route. The first
	// step is a diagonal of one LSB, whose root rounds down to one.
	task automatic test_route_continuation();
		send_point(route_point(24'sd6, -24'sd6, 1'b0, 1'b0));
		send_point(route_point(24'sd6, 24'sd250, 1'b0, 1'b1));
		wait_drain();
	endtask

	// The status compares with a strict greater-than: a total equal to the limit
	// passes, one LSB above fails, and the largest limit passes everything.
	task automatic test_limit_boundary();
		logic [plc_pkg::TOTAL_W-1:0] limits[3];
		limits = '{40'd1280, 40'd1279, plc_pkg::TOTAL_MAX};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			send_point(route_point(24'sd0, 24'sd0, 1'b1, 1'b0));
			send_point(route_point(24'sd768, 24'sd1024, 1'b0, 1'b1));
			wait_drain();
		end
	endtask

	// Corner-to-corner steps give the widest differences the coordinates allow; a
	// repeated point adds a segment of zero.
	task automatic test_coordinate_extremes();
		write_limit(40'd50_000_000);
		send_point(route_point(COORD_MIN, COORD_MIN, 1'b1, 1'b0));
		send_point(route_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0));
		send_point(route_point(COORD_MIN, COORD_MAX, 1'b0, 1'b0));
		send_point(route_point(COORD_MAX, COORD_MIN, 1'b0, 1'b0));
		send_point(route_point(COORD_MAX, COORD_MIN, 1'b0, 1'b0));
		send_point(route_point(24'sd0, -24'sd1, 1'b0, 1'b1));
		wait_drain();
	endtask

	// Coordinates are mostly random, sometimes a short step from the last point,
	// sometimes a corner value, and sometimes the last point itself.
	function automatic logic signed [plc_pkg::COORD_W-1:0] pick_coord(
			input logic signed [plc_pkg::COORD_W-1:0] near);
		int unsigned sel;
		logic signed [plc_pkg::COORD_W-1:0] c;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			c = plc_pkg::COORD_W'($urandom);
		end else if (sel < 8) begin
			c = near + plc_pkg::COORD_W'($urandom_range(0, 2047))
				- plc_pkg::COORD_W'(1024);
		end else if (sel == 8) begin
			case ($urandom_range(0, 3))
				0: c = COORD_MIN;
				1: c = COORD_MAX;
				2: c = '0;
				default: c = '1;
			endcase
		end else begin
			c = near;
		end
		return c;
	endfunction

	// The first two phases use the extreme limits; later ones mostly land near the
	// totals that short routes produce, so both status values show up.
	function automatic logic [plc_pkg::TOTAL_W-1:0] pick_limit(input int phase);
		if (phase == 0)
			return '0;
		if (phase == 1)
			return plc_pkg::TOTAL_MAX;
		if ($urandom_range(0, 3) == 0)
			return plc_pkg::TOTAL_W'({$urandom, $urandom});
		return plc_pkg::TOTAL_W'($urandom_range(0, 32'h0800_0000));
	endfunction

	// Mostly well-formed routes of random length and content, with some runs of
	// points whose start and end flags are random. The limit changes between phases
	// once the block is idle, and now and then the sender waits for every report.
	task automatic test_random_routes();
		int sent;
		int phase;
		int len;
		bit noise;
		logic signed [plc_pkg::COORD_W-1:0] x;
		logic signed [plc_pkg::COORD_W-1:0] y;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= phase * PHASE_ITEMS) begin
				wait_drain();
				write_limit(pick_limit(phase));
				phase++;
			end
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 19) == 0)
				wait_drain();
			noise = ($urandom_range(0, 6) == 0);
			if (noise)
				len = $urandom_range(1, 6);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, 40);
			else
				len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				x = pick_coord(prev_x);
				y = pick_coord(prev_y);
				if (noise)
					send_point(route_point(x, y, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
				else
					send_point(route_point(x, y, i == 0, i == len - 1));
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		pt_valid  = 1'b0;
		pt        = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		prev_x    = '0;
		prev_y    = '0;
		run_total = '0;
		run_count = '0;
		limit_reg = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unstarted_route();
		test_single_point_route();
		test_route_continuation();
		test_limit_boundary();
		test_coordinate_extremes();
		test_random_routes();

		wait_drain();
		if (mismatches == 0 && readback_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> path_length_limit_check.f
rtl/plc_pkg.sv
rtl/plc_isqrt.sv
rtl/path_length_limit_check.sv
sim/path_length_limit_check_tb.sv
